// File: hw/rtl/hic_pkg.sv
package hic_pkg;

  // Levels the position can feed: one base-4 digit per level, 32-bit fraction
  localparam int LEVELS = 16;
  localparam int HALF_LEVELS = LEVELS / 2;
  localparam int MAX_DEPTH = 16;
  localparam int DEPTH_LIMIT = (MAX_DEPTH < LEVELS) ? MAX_DEPTH : LEVELS;

  localparam int POS_W = 32;
  localparam int CELL_W = 16;
  localparam int DEPTH_W = 5;
  localparam int ORIENT_W = 2;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_INDEX_W = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIENT = 1'd1;

  // Orientation codes
  localparam logic [ORIENT_W-1:0] OR_UP = 2'd0;
  localparam logic [ORIENT_W-1:0] OR_DOWN = 2'd1;
  localparam logic [ORIENT_W-1:0] OR_LEFT = 2'd2;
  localparam logic [ORIENT_W-1:0] OR_RIGHT = 2'd3;

  // Quadrant codes: bit 0 is the column bit, bit 1 the row bit
  localparam logic [1:0] Q_BL = 2'd0;
  localparam logic [1:0] Q_BR = 2'd1;
  localparam logic [1:0] Q_TL = 2'd2;
  localparam logic [1:0] Q_TR = 2'd3;

  // Orientation map: entry o holds the orientation reached from orientation o
  typedef logic [3:0][ORIENT_W-1:0] omap_t;

  // Quadrant visited for a digit under an orientation
  function automatic logic [1:0] quad_of_digit(input logic [ORIENT_W-1:0] orient,
                                               input logic [1:0] digit);
    logic [1:0] q;
    q = Q_BL;
    unique case (orient)
      OR_UP: begin
        case (digit)
          2'd0: q = Q_BL;
          2'd1: q = Q_TL;
          2'd2: q = Q_TR;
          default: q = Q_BR;
        endcase
      end
      OR_DOWN: begin
        case (digit)
          2'd0: q = Q_TR;
          2'd1: q = Q_BR;
          2'd2: q = Q_BL;
          default: q = Q_TL;
        endcase
      end
      OR_LEFT: begin
        case (digit)
          2'd0: q = Q_TR;
          2'd1: q = Q_TL;
          2'd2: q = Q_BL;
          default: q = Q_BR;
        endcase
      end
      default: begin
        case (digit)
          2'd0: q = Q_BL;
          2'd1: q = Q_BR;
          2'd2: q = Q_TR;
          default: q = Q_TL;
        endcase
      end
    endcase
    return q;
  endfunction

  // Orientation of the child cell in a quadrant
  function automatic logic [ORIENT_W-1:0] child_orient(input logic [ORIENT_W-1:0] orient,
                                                       input logic [1:0] quad);
    logic [ORIENT_W-1:0] c;
    c = OR_UP;
    unique case (orient)
      OR_UP: begin
        case (quad)
          Q_BL: c = OR_RIGHT;
          Q_BR: c = OR_LEFT;
          Q_TL: c = OR_UP;
          default: c = OR_UP;
        endcase
      end
      OR_DOWN: begin
        case (quad)
          Q_BL: c = OR_DOWN;
          Q_BR: c = OR_DOWN;
          Q_TL: c = OR_RIGHT;
          default: c = OR_LEFT;
        endcase
      end
      OR_LEFT: begin
        case (quad)
          Q_BL: c = OR_LEFT;
          Q_BR: c = OR_UP;
          Q_TL: c = OR_LEFT;
          default: c = OR_DOWN;
        endcase
      end
      default: begin
        case (quad)
          Q_BL: c = OR_UP;
          Q_BR: c = OR_RIGHT;
          Q_TL: c = OR_DOWN;
          default: c = OR_RIGHT;
        endcase
      end
    endcase
    return c;
  endfunction

  // Apply map a, then map b
  function automatic omap_t compose(input omap_t a, input omap_t b);
    omap_t r;
    for (int o = 0; o < 4; o++) begin
      r[o] = b[a[o]];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/hilbert_index_to_cell.sv
// Channel  Handshake            Payload
// -------  -------------------  --------------------------------------
// in       in_valid / in_stall  curve_position[31:0]
// out      out_valid/ out_stall cell_column[15:0], cell_row[15:0]
// cfg      cfg_write            cfg_index[0], cfg_data[4:0]
//
// A word enters the input register at its accepting edge and then passes
// through the mapping logic into the result register, setting out_valid, when
// the latter is empty or taken. One word can be accepted every cycle; the input
// register holds the next word while a finished result waits under out_stall,
// so in_stall rises only when both registers are full and the output is stalled.
// rst clears both valid flags and loads depth 16, orientation up.
module hilbert_index_to_cell import hic_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [POS_W-1:0]       curve_position,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CELL_W-1:0]      cell_column,
  output logic [CELL_W-1:0]      cell_row,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration
  logic [DEPTH_W-1:0]  depth_in_use;
  logic [ORIENT_W-1:0] start_orientation;

  // Input register
  logic                pos_valid;
  logic [POS_W-1:0]    pos_reg;

  logic in_accept;
  logic out_load;

  // Mapping logic
  logic [LEVELS-1:0][1:0]          digit;
  logic [LEVELS-1:0][1:0]          quad_at;
  logic [LEVELS-1:0][ORIENT_W-1:0] orient_at;
  omap_t [HALF_LEVELS-1:0]         step_map;
  omap_t [3:0]                     pair_map;
  omap_t [1:0]                     quad_map;
  omap_t                           half_map;
  logic [CELL_W-1:0]               full_col;
  logic [CELL_W-1:0]               full_row;
  logic [DEPTH_W-1:0]              depth_eff;
  logic [DEPTH_W-1:0]              shift_amt;
  logic [CELL_W-1:0]               cell_column_next;
  logic [CELL_W-1:0]               cell_row_next;

  // Move a word into the result register when it is empty or being taken
  assign out_load  = pos_valid && (!out_valid || !out_stall);
  assign in_stall  = pos_valid && !out_load;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      digit[k] = pos_reg[POS_W-1-2*k -: 2];
    end

    // Orientation map of each upper-half level, then fold them in a tree so
    // the orientation at the middle level is known without walking the chain
    for (int k = 0; k < HALF_LEVELS; k++) begin
      for (int o = 0; o < 4; o++) begin
        step_map[k][o] = child_orient(ORIENT_W'(o), quad_of_digit(ORIENT_W'(o), digit[k]));
      end
    end
    for (int j = 0; j < 4; j++) begin
      pair_map[j] = compose(step_map[2*j], step_map[2*j+1]);
    end
    for (int j = 0; j < 2; j++) begin
      quad_map[j] = compose(pair_map[2*j], pair_map[2*j+1]);
    end
    half_map = compose(quad_map[0], quad_map[1]);

    // Two independent chains of eight levels each
    orient_at[0]           = start_orientation;
    orient_at[HALF_LEVELS] = half_map[start_orientation];
    for (int i = 0; i < HALF_LEVELS; i++) begin
      quad_at[i] = quad_of_digit(orient_at[i], digit[i]);
      quad_at[HALF_LEVELS+i] = quad_of_digit(orient_at[HALF_LEVELS+i],
                                             digit[HALF_LEVELS+i]);
      if (i < HALF_LEVELS - 1) begin
        orient_at[i+1] = child_orient(orient_at[i], quad_at[i]);
        orient_at[HALF_LEVELS+i+1] = child_orient(orient_at[HALF_LEVELS+i],
                                                  quad_at[HALF_LEVELS+i]);
      end
    end

    for (int k = 0; k < LEVELS; k++) begin
      full_col[CELL_W-1-k] = quad_at[k][0];
      full_row[CELL_W-1-k] = quad_at[k][1];
    end

    // Keep only the top depth levels: drop the rest by a right shift
    if (depth_in_use > DEPTH_W'(DEPTH_LIMIT)) begin
      depth_eff = DEPTH_W'(DEPTH_LIMIT);
    end else begin
      depth_eff = depth_in_use;
    end
    shift_amt        = DEPTH_W'(LEVELS) - depth_eff;
    cell_column_next = full_col >> shift_amt;
    cell_row_next    = full_row >> shift_amt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_in_use      <= DEPTH_W'(LEVELS);
      start_orientation <= OR_UP;
      pos_valid         <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DEPTH:  depth_in_use      <= cfg_data[DEPTH_W-1:0];
          REG_ORIENT: start_orientation <= cfg_data[ORIENT_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        pos_valid <= 1'b1;
      end else if (out_load) begin
        pos_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    // Payload: hold while stalled
    if (in_accept) begin
      pos_reg <= curve_position;
    end
    if (out_load) begin
      cell_column <= cell_column_next;
      cell_row    <= cell_row_next;
    end
  end

endmodule
